/* design/union_find_pair_counter_macros.svh */
// ----------------------------------------------------------------------------
// union_find_pair_counter macros
// Assertion helpers for the disjoint-set pair counter.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_PAIR_COUNTER_MACROS_SVH
`define UNION_FIND_PAIR_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
`define UFPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define UFPC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define UFPC_ASSERT(lbl, prop, msg)
`define UFPC_NEVER(lbl, cond, msg)
`endif

`endif

/* design/ufpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufpc_pkg
// Shared types and constants of the disjoint-set pair counter.
// ----------------------------------------------------------------------------
package ufpc_pkg;

  localparam int NodeW    = 16;
  localparam int CfgW     = 17;
  localparam int PairW    = 31;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic [CfgW-1:0] NumNodesRst = 17'h10000;

  typedef enum logic {
    KIND_CLEAR = 1'b0,
    KIND_UNION = 1'b1
  } kind_e;

  typedef enum logic [ApbAddrW-3:0] {
    REG_NUM_NODES = 1'b0
  } reg_idx_e;

endpackage

/* design/ufpc_node_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufpc_node_ram
// Node table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ufpc_node_ram #(
  parameter int Depth = 65536,
  parameter int Width = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/union_find_pair_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_pair_counter
// Disjoint-set forest with component sizes and a count of unconnected pairs.
// ----------------------------------------------------------------------------
// channel  direction  handshake                  word
// in       input      in_valid_i / in_ready_o    kind_i, node_a_i, node_b_i
// out      output     out_valid_o / out_ready_i  disconnected_pairs_o, merged_o
// cfg      input      psel/penable/pwrite, pready num_nodes at paddr 0
//
// Union that joins: ST_FA and ST_FB walk the parent links of each node, one
// read of the node table per hop, then ST_MUL and ST_UPD link the roots;
// same component: ST_FA and ST_FB only; a node out of range: neither. Clear:
// ST_SWEEP writes the table once per node of the clamped count. After reset a
// sweep of min(MAX_NODES, 65536) nodes initializes it; in_ready_o stays low.
// A stalled output holds its word; the next item is still taken.
// ----------------------------------------------------------------------------
`include "union_find_pair_counter_macros.svh"

module union_find_pair_counter #(
  parameter int MAX_NODES = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ufpc_pkg::ApbAddrW-1:0]   paddr,
  input  logic [ufpc_pkg::ApbDataW-1:0]   pwdata,
  output logic [ufpc_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [ufpc_pkg::NodeW-1:0]      node_a_i,
  input  logic [ufpc_pkg::NodeW-1:0]      node_b_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ufpc_pkg::PairW-1:0]      disconnected_pairs_o,
  output logic                            merged_o
);

  import ufpc_pkg::*;

  localparam int NodeLimit = (MAX_NODES < 65536) ? MAX_NODES : 65536;
  localparam int IdxW      = $clog2(NodeLimit);
  localparam int SzW       = IdxW + 1;
  localparam int ProdW     = 2 * SzW;
  localparam int CmpW      = (ProdW > PairW) ? ProdW : PairW;
  localparam longint unsigned PairRst =
    (longint'(NodeLimit) * longint'(NodeLimit - 1)) / 2;

  typedef struct packed {
    logic [SzW-1:0]  size;
    logic [IdxW-1:0] parent;
  } node_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FA,
    ST_FB,
    ST_MUL,
    ST_UPD,
    ST_SWEEP,
    ST_CLR_END,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic              boot_q, boot_d;
  logic              out_valid_q, out_valid_d;
  logic [CfgW-1:0]   num_nodes_q, num_nodes_d;
  logic [SzW-1:0]    active_q, active_d;
  logic [PairW-1:0]  pair_q, pair_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;

  logic [PairW-1:0]  pre_q, pre_d;
  logic              merged_q, merged_d;
  logic [PairW-1:0]  out_pairs_q, out_pairs_d;
  logic              out_merged_q, out_merged_d;
  logic [IdxW-1:0]   a_q, a_d, b_q, b_d, cur_q, cur_d, ra_q, ra_d;
  logic [SzW-1:0]    sza_q, sza_d, szb_q, szb_d;
  logic [SzW-1:0]    op_x_q, op_x_d, op_y_q, op_y_d;
  logic [ProdW-1:0]  prod_q;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  node_t             ram_wdata, rd_w;

  logic [CfgW-1:0]   clamped;
  logic              a_in_range, b_in_range, sweep_last;
  logic [CmpW-1:0]   prod_ext, pair_ext, half_prod;

  ufpc_node_ram #(
    .Depth (NodeLimit),
    .Width ($bits(node_t))
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_w)
  );

  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[ApbAddrW-1:2])
      REG_NUM_NODES: prdata = ApbDataW'(num_nodes_q);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    if (num_nodes_q == '0) begin
      clamped = CfgW'(1);
    end else if (num_nodes_q > CfgW'(NodeLimit)) begin
      clamped = CfgW'(NodeLimit);
    end else begin
      clamped = num_nodes_q;
    end
  end

  assign a_in_range = ({1'b0, node_a_i} < CfgW'(active_q));
  assign b_in_range = ({1'b0, node_b_i} < CfgW'(active_q));
  assign sweep_last = ({1'b0, cnt_q} == (active_q - SzW'(1)));
  assign prod_ext   = CmpW'(prod_q);
  assign pair_ext   = CmpW'(pair_q);
  assign half_prod  = prod_ext >> 1;

  always_comb begin
    state_d      = state_q;
    boot_d       = boot_q;
    out_valid_d  = out_valid_q;
    num_nodes_d  = num_nodes_q;
    active_d     = active_q;
    pair_d       = pair_q;
    cnt_d        = cnt_q;
    pre_d        = pre_q;
    merged_d     = merged_q;
    out_pairs_d  = out_pairs_q;
    out_merged_d = out_merged_q;
    a_d          = a_q;
    b_d          = b_q;
    cur_d        = cur_q;
    ra_d         = ra_q;
    sza_d        = sza_q;
    szb_d        = szb_q;
    op_x_d       = op_x_q;
    op_y_d       = op_y_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_q;
    ram_wdata    = '0;
    ram_raddr    = cur_q;

    if (psel && penable && pwrite && (paddr[ApbAddrW-1:2] == REG_NUM_NODES)) begin
      num_nodes_d = pwdata[CfgW-1:0];
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        ram_raddr = node_a_i[IdxW-1:0];
        if (in_valid_i) begin
          pre_d    = pair_q;
          merged_d = 1'b0;
          a_d      = node_a_i[IdxW-1:0];
          b_d      = node_b_i[IdxW-1:0];
          cur_d    = node_a_i[IdxW-1:0];
          if (kind_i == KIND_CLEAR) begin
            active_d = clamped[SzW-1:0];
            op_x_d   = clamped[SzW-1:0];
            op_y_d   = clamped[SzW-1:0] - SzW'(1);
            cnt_d    = '0;
            state_d  = ST_SWEEP;
          end else if (a_in_range && b_in_range) begin
            state_d = ST_FA;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FA: begin
        if (rd_w.parent == cur_q) begin
          ra_d      = cur_q;
          sza_d     = rd_w.size;
          ram_we    = (cur_q != a_q);
          ram_waddr = a_q;
          ram_wdata = '{size: rd_w.size, parent: cur_q};
          ram_raddr = b_q;
          cur_d     = b_q;
          state_d   = ST_FB;
        end else begin
          ram_raddr = rd_w.parent;
          cur_d     = rd_w.parent;
        end
      end
      ST_FB: begin
        if (rd_w.parent == cur_q) begin
          szb_d     = rd_w.size;
          ram_we    = (cur_q != b_q);
          ram_waddr = b_q;
          ram_wdata = '{size: rd_w.size, parent: cur_q};
          op_x_d    = sza_q;
          op_y_d    = rd_w.size;
          state_d   = (cur_q == ra_q) ? ST_FINISH : ST_MUL;
        end else begin
          ram_raddr = rd_w.parent;
          cur_d     = rd_w.parent;
        end
      end
      ST_MUL: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = '{size: szb_q, parent: ra_q};
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = ra_q;
        ram_wdata = '{size: sza_q + szb_q, parent: ra_q};
        pair_d    = (prod_ext <= pair_ext) ? PairW'(pair_ext - prod_ext) : '0;
        merged_d  = 1'b1;
        state_d   = ST_FINISH;
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = '{size: SzW'(1), parent: cnt_q};
        cnt_d     = cnt_q + IdxW'(1);
        if (sweep_last) begin
          state_d = ST_CLR_END;
        end
      end
      ST_CLR_END: begin
        pair_d  = PairW'(half_prod);
        boot_d  = 1'b0;
        state_d = boot_q ? ST_IDLE : ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_pairs_d  = pre_q;
          out_merged_d = merged_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      boot_q       <= 1'b1;
      out_valid_q  <= 1'b0;
      num_nodes_q  <= NumNodesRst;
      active_q     <= SzW'(NodeLimit);
      pair_q       <= PairW'(PairRst);
      cnt_q        <= '0;
      op_x_q       <= SzW'(NodeLimit);
      op_y_q       <= SzW'(NodeLimit - 1);
      pre_q        <= '0;
      merged_q     <= 1'b0;
      out_pairs_q  <= '0;
      out_merged_q <= 1'b0;
      a_q          <= '0;
      b_q          <= '0;
      cur_q        <= '0;
      ra_q         <= '0;
      sza_q        <= '0;
      szb_q        <= '0;
      prod_q       <= '0;
    end else begin
      state_q      <= state_d;
      boot_q       <= boot_d;
      out_valid_q  <= out_valid_d;
      num_nodes_q  <= num_nodes_d;
      active_q     <= active_d;
      pair_q       <= pair_d;
      cnt_q        <= cnt_d;
      op_x_q       <= op_x_d;
      op_y_q       <= op_y_d;
      pre_q        <= pre_d;
      merged_q     <= merged_d;
      out_pairs_q  <= out_pairs_d;
      out_merged_q <= out_merged_d;
      a_q          <= a_d;
      b_q          <= b_d;
      cur_q        <= cur_d;
      ra_q         <= ra_d;
      sza_q        <= sza_d;
      szb_q        <= szb_d;
      prod_q       <= op_x_q * op_y_q;
    end
  end

  assign in_ready_o           = (state_q == ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign disconnected_pairs_o = out_pairs_q;
  assign merged_o             = out_merged_q;

  `UFPC_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready after accept")
  `UFPC_ASSERT(a_pairs_no_growth, (state_q != ST_CLR_END) |=> (pair_q <= $past(pair_q)), "pairs grew")
  `UFPC_NEVER(a_sweep_in_range, (state_q == ST_SWEEP) && ({1'b0, cnt_q} >= active_q), "sweep overrun")

endmodule
